// ===== sv/hsfd_pkg.sv =====
// Package for the Huffman stream file decoder: word types, phases, constants.
// Used by hsfd_node_store and huffman_stream_file_decoder.
package hsfd_pkg;

  localparam int MAX_SYMBOLS = 256;
  localparam int NODE_DEPTH  = 512;
  localparam int NODE_W      = $clog2(NODE_DEPTH);
  localparam int USED_W      = $clog2(NODE_DEPTH + 1);
  localparam int PAIR_W      = $clog2(MAX_SYMBOLS);
  localparam int PCNT_W      = $clog2(MAX_SYMBOLS + 1);

  localparam logic [7:0] MAGIC0 = 8'h48;
  localparam logic [7:0] MAGIC1 = 8'h45;
  localparam logic [7:0] MAGIC2 = 8'h33;
  localparam logic [7:0] MAGIC3 = 8'h0d;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_EDGE = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       file_start;
  } in_word_t;

  typedef struct packed {
    logic [7:0] symbol;
    logic [1:0] status;
    logic       magic_ok;
    logic       last;
  } out_word_t;

  // control states
  typedef enum logic [3:0] {
    S_INIT,      // clear root node
    S_IDLE,      // wait for next word
    S_BYTE,      // dispatch the held byte
    S_SETTLE_W,  // wait for node and pair reads
    S_SETTLE,    // mark leaf for a finished code
    S_CODE,      // build: one code bit
    S_NEW,       // build: write new empty node
    S_DEC,       // decode: one data bit
    S_DEC_W,     // decode: wait for child read
    S_DEC_CHK,   // decode: leaf check
    S_EMIT       // hold a result word
  } phase_t;

  // where the stream is in the file
  typedef enum logic [2:0] {
    PS_HEADER,
    PS_PAIRS,
    PS_CODES,
    PS_DECODE,
    PS_DONE
  } parse_t;

  // one node store entry: left, right, leaf flag, symbol
  typedef struct packed {
    logic [NODE_W-1:0] left;
    logic [NODE_W-1:0] right;
    logic              leaf;
    logic [7:0]        sym;
  } node_t;

  function automatic logic [7:0] magic_at(input logic [1:0] idx);
    logic [7:0] m;
    case (idx)
      2'd0:    m = MAGIC0;
      2'd1:    m = MAGIC1;
      2'd2:    m = MAGIC2;
      default: m = MAGIC3;
    endcase
    return m;
  endfunction

endpackage

// ===== sv/hsfd_node_store.sv =====
// Node store of the code tree: one write port, one registered read port.
// Depends on hsfd_pkg.
module hsfd_node_store (
  input  logic                      clk,
  input  logic                      we,
  input  logic [hsfd_pkg::NODE_W-1:0] waddr,
  input  hsfd_pkg::node_t           wdata,
  input  logic [hsfd_pkg::NODE_W-1:0] raddr,
  output hsfd_pkg::node_t           rdata
);

  hsfd_pkg::node_t mem [hsfd_pkg::NODE_DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/huffman_stream_file_decoder.sv =====
// Huffman stream file decoder: parses header, builds the code tree, decodes.
// Each input word is taken in S_IDLE and dispatched in S_BYTE; a file_start word
// first clears the parse state. Code bits walk the tree and add nodes, finished codes
// mark leaves; data bits walk the tree, and result words wait for out_ready.
// Sync rst clears control state; the next cycle clears the root node. Nodes are
// cleared as they are allocated. Depends on hsfd_pkg and hsfd_node_store.
module huffman_stream_file_decoder (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  hsfd_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output hsfd_pkg::out_word_t out_data
);

  localparam int NW = hsfd_pkg::NODE_W;
  localparam int UW = hsfd_pkg::USED_W;
  localparam int PW = hsfd_pkg::PAIR_W;
  localparam int CW = hsfd_pkg::PCNT_W;

  hsfd_pkg::phase_t state, state_next;
  hsfd_pkg::parse_t parse;

  logic          restart;
  logic [3:0]    byte_index;
  logic [31:0]   output_length;
  logic [15:0]   symbol_count;
  logic [15:0]   pairs_seen;
  logic [7:0]    pair_sym;
  logic [CW-1:0] pair_cursor;
  logic [7:0]    code_bit_count;
  logic [UW-1:0] nodes_used;
  logic [NW-1:0] current_node;
  logic [31:0]   symbols_left;
  logic          magic_flag;
  logic [7:0]    shreg;     // data bits, LSB shifted out first
  logic [3:0]    bits_left;
  logic [7:0]    o_sym;
  logic [1:0]    o_status;
  logic          o_last;

  // pair table memory
  logic [15:0]   pair_table [hsfd_pkg::MAX_SYMBOLS];
  logic [15:0]   pair_rd;
  logic [PW-1:0] pt_raddr;

  // node store ports
  logic            ns_we;
  logic [NW-1:0]   ns_waddr, ns_raddr;
  hsfd_pkg::node_t ns_wdata, ns_rd;

  hsfd_node_store u_store (
    .clk(clk), .we(ns_we), .waddr(ns_waddr), .wdata(ns_wdata),
    .raddr(ns_raddr), .rdata(ns_rd)
  );

  logic [CW-1:0] stored;
  assign stored = (symbol_count < 16'(hsfd_pkg::MAX_SYMBOLS)) ?
                  CW'(symbol_count) : CW'(hsfd_pkg::MAX_SYMBOLS);

  logic accept;
  assign accept = in_valid && in_ready;

  // node store always reads the current node
  assign ns_raddr = current_node;

  logic bit_now;
  assign bit_now = shreg[0];
  logic [NW-1:0] child;
  assign child = bit_now ? ns_rd.right : ns_rd.left;

  logic settle_hit, codes_done, root_leaf, node_full, hdr_last, hdr_no_syms, pair_last;
  assign settle_hit  = (pair_cursor < stored) && (code_bit_count >= pair_rd[15:8]);
  assign codes_done  = (pair_cursor >= stored);
  assign root_leaf   = (current_node == '0) && ns_rd.leaf;
  assign node_full   = (nodes_used >= UW'(hsfd_pkg::NODE_DEPTH));
  assign hdr_last    = (byte_index >= 4'd10);
  assign hdr_no_syms = (symbol_count[7:0] == 8'd0) && (shreg == 8'd0);
  assign pair_last   = byte_index[0] && ((pairs_seen + 16'd1) >= symbol_count);

  // pair table: write on second byte of a pair, registered read at cursor
  assign pt_raddr = pair_cursor[PW-1:0];
  always_ff @(posedge clk) begin
    if (state == hsfd_pkg::S_BYTE && !restart && parse == hsfd_pkg::PS_PAIRS &&
        byte_index[0] && pairs_seen < 16'(hsfd_pkg::MAX_SYMBOLS)) begin
      pair_table[pairs_seen[PW-1:0]] <= {shreg, pair_sym};
    end
    pair_rd <= pair_table[pt_raddr];
  end

  // result word
  always_comb begin
    out_data.symbol   = o_sym;
    out_data.status   = o_status;
    out_data.magic_ok = magic_flag;
    out_data.last     = o_last;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      hsfd_pkg::S_INIT: state_next = hsfd_pkg::S_IDLE;
      hsfd_pkg::S_IDLE: if (accept) state_next = hsfd_pkg::S_BYTE;
      hsfd_pkg::S_BYTE: begin
        if (!restart) begin
          case (parse)
            hsfd_pkg::PS_HEADER:
              state_next = (hdr_last && hdr_no_syms) ? hsfd_pkg::S_SETTLE_W : hsfd_pkg::S_IDLE;
            hsfd_pkg::PS_PAIRS:
              state_next = pair_last ? hsfd_pkg::S_SETTLE_W : hsfd_pkg::S_IDLE;
            hsfd_pkg::PS_CODES:  state_next = hsfd_pkg::S_CODE;
            hsfd_pkg::PS_DECODE: state_next = hsfd_pkg::S_DEC;
            default:             state_next = hsfd_pkg::S_IDLE;
          endcase
        end
      end
      hsfd_pkg::S_SETTLE_W: state_next = hsfd_pkg::S_SETTLE;
      hsfd_pkg::S_SETTLE: begin
        if (settle_hit) state_next = hsfd_pkg::S_SETTLE_W;
        else if (codes_done || bits_left == 4'd0) state_next = hsfd_pkg::S_IDLE;
        else state_next = hsfd_pkg::S_CODE;
      end
      hsfd_pkg::S_CODE: begin
        if (bits_left == 4'd0) state_next = hsfd_pkg::S_IDLE;
        else if (child != '0) state_next = hsfd_pkg::S_SETTLE_W;
        else if (node_full) state_next = hsfd_pkg::S_EMIT;
        else state_next = hsfd_pkg::S_NEW;
      end
      hsfd_pkg::S_NEW: state_next = hsfd_pkg::S_SETTLE_W;
      hsfd_pkg::S_DEC: begin
        if (bits_left == 4'd0) state_next = hsfd_pkg::S_IDLE;
        else if (root_leaf || child == '0) state_next = hsfd_pkg::S_EMIT;
        else state_next = hsfd_pkg::S_DEC_W;
      end
      hsfd_pkg::S_DEC_W: state_next = hsfd_pkg::S_DEC_CHK;
      hsfd_pkg::S_DEC_CHK:
        state_next = ns_rd.leaf ? hsfd_pkg::S_EMIT : hsfd_pkg::S_DEC;
      hsfd_pkg::S_EMIT:
        if (out_ready) state_next = o_last ? hsfd_pkg::S_IDLE : hsfd_pkg::S_DEC;
      default: state_next = hsfd_pkg::S_IDLE;
    endcase
  end

  // handshakes and node store writes
  always_comb begin
    in_ready  = (state == hsfd_pkg::S_IDLE);
    out_valid = (state == hsfd_pkg::S_EMIT);
    ns_we     = 1'b0;
    ns_waddr  = current_node;
    ns_wdata  = '0;
    case (state)
      hsfd_pkg::S_INIT: begin
        ns_we    = 1'b1;
        ns_waddr = '0;
      end
      hsfd_pkg::S_BYTE: begin
        if (restart) begin
          ns_we    = 1'b1;
          ns_waddr = '0;
        end
      end
      hsfd_pkg::S_SETTLE: begin
        if (settle_hit) begin
          ns_we         = 1'b1;
          ns_wdata      = ns_rd;
          ns_wdata.leaf = 1'b1;
          ns_wdata.sym  = pair_rd[7:0];
        end
      end
      hsfd_pkg::S_CODE: begin
        if (bits_left != 4'd0 && child == '0 && !node_full) begin
          ns_we    = 1'b1;
          ns_wdata = ns_rd;
          if (bit_now) ns_wdata.right = nodes_used[NW-1:0];
          else ns_wdata.left = nodes_used[NW-1:0];
        end
      end
      hsfd_pkg::S_NEW: begin
        ns_we    = 1'b1;
        ns_waddr = nodes_used[NW-1:0];
      end
      default: ;
    endcase
  end

  // state register and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hsfd_pkg::S_INIT;
      parse <= hsfd_pkg::PS_HEADER;
      restart <= 1'b0;
      byte_index <= '0; output_length <= '0; symbol_count <= '0; pairs_seen <= '0;
      pair_sym <= '0; pair_cursor <= '0; code_bit_count <= '0; nodes_used <= UW'(1);
      current_node <= '0; symbols_left <= '0; magic_flag <= 1'b1;
      shreg <= '0; bits_left <= '0;
      o_sym <= '0; o_status <= hsfd_pkg::ST_OK; o_last <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        hsfd_pkg::S_IDLE: begin
          if (accept) begin
            shreg   <= in_data.in_byte;
            restart <= in_data.file_start;
          end
        end
        hsfd_pkg::S_BYTE: begin
          if (restart) begin
            // new file: clear parse state and root node, then handle the byte as header
            restart <= 1'b0;
            parse <= hsfd_pkg::PS_HEADER;
            byte_index <= '0; output_length <= '0; symbol_count <= '0;
            pairs_seen <= '0; pair_cursor <= '0; code_bit_count <= '0;
            nodes_used <= UW'(1); current_node <= '0; symbols_left <= '0;
            magic_flag <= 1'b1;
          end else begin
            case (parse)
              hsfd_pkg::PS_HEADER: begin
                bits_left <= 4'd0;
                case (byte_index)
                  4'd0, 4'd1, 4'd2, 4'd3:
                    if (shreg != hsfd_pkg::magic_at(byte_index[1:0])) magic_flag <= 1'b0;
                  4'd5: output_length[7:0]   <= shreg;
                  4'd6: output_length[15:8]  <= shreg;
                  4'd7: output_length[23:16] <= shreg;
                  4'd8: output_length[31:24] <= shreg;
                  4'd9: symbol_count[7:0]    <= shreg;
                  4'd10: symbol_count[15:8]  <= shreg;
                  default: ;
                endcase
                if (hdr_last) begin
                  byte_index <= '0;
                  if (hdr_no_syms) begin
                    pair_cursor <= '0; code_bit_count <= '0; current_node <= '0;
                    parse <= hsfd_pkg::PS_CODES;
                  end else begin
                    parse <= hsfd_pkg::PS_PAIRS;
                  end
                end else begin
                  byte_index <= byte_index + 4'd1;
                end
              end
              hsfd_pkg::PS_PAIRS: begin
                bits_left <= 4'd0;
                if (!byte_index[0]) begin
                  pair_sym <= shreg;
                  byte_index <= 4'd1;
                end else begin
                  byte_index <= '0;
                  pairs_seen <= pairs_seen + 16'd1;
                  if (pair_last) begin
                    pair_cursor <= '0; code_bit_count <= '0; current_node <= '0;
                    parse <= hsfd_pkg::PS_CODES;
                  end
                end
              end
              hsfd_pkg::PS_CODES, hsfd_pkg::PS_DECODE: bits_left <= 4'd8;
              default: ;
            endcase
          end
        end
        hsfd_pkg::S_SETTLE: begin
          if (settle_hit) begin
            pair_cursor <= pair_cursor + CW'(1);
            code_bit_count <= '0;
            current_node <= '0;
          end else if (codes_done) begin
            // tree complete: rest of this byte is padding
            symbols_left <= output_length;
            current_node <= '0;
            parse <= (output_length != 32'd0) ? hsfd_pkg::PS_DECODE : hsfd_pkg::PS_DONE;
          end
        end
        hsfd_pkg::S_CODE: begin
          if (bits_left != 4'd0) begin
            if (child != '0) begin
              current_node <= child;
              code_bit_count <= code_bit_count + 8'd1;
              shreg <= {1'b0, shreg[7:1]};
              bits_left <= bits_left - 4'd1;
            end else if (node_full) begin
              o_sym <= '0; o_status <= hsfd_pkg::ST_FULL; o_last <= 1'b1;
            end
          end
        end
        hsfd_pkg::S_NEW: begin
          current_node <= nodes_used[NW-1:0];
          nodes_used <= nodes_used + UW'(1);
          code_bit_count <= code_bit_count + 8'd1;
          shreg <= {1'b0, shreg[7:1]};
          bits_left <= bits_left - 4'd1;
        end
        hsfd_pkg::S_DEC: begin
          if (bits_left != 4'd0) begin
            if (root_leaf) begin
              // leaf root: each bit yields the root symbol
              shreg <= {1'b0, shreg[7:1]};
              bits_left <= bits_left - 4'd1;
              symbols_left <= symbols_left - 32'd1;
              o_sym <= ns_rd.sym; o_status <= hsfd_pkg::ST_OK;
              o_last <= (symbols_left == 32'd1);
            end else if (child == '0) begin
              o_sym <= '0; o_status <= hsfd_pkg::ST_NO_EDGE; o_last <= 1'b1;
            end else begin
              current_node <= child;
              shreg <= {1'b0, shreg[7:1]};
              bits_left <= bits_left - 4'd1;
            end
          end
        end
        hsfd_pkg::S_DEC_CHK: begin
          if (ns_rd.leaf) begin
            symbols_left <= symbols_left - 32'd1;
            o_sym <= ns_rd.sym; o_status <= hsfd_pkg::ST_OK;
            o_last <= (symbols_left == 32'd1);
            current_node <= '0;
          end
        end
        hsfd_pkg::S_EMIT: begin
          if (out_ready && o_last) parse <= hsfd_pkg::PS_DONE;
        end
        default: ;
      endcase
    end
  end

endmodule
